[rtl/csvft_pkg.sv]
// Package for the CSV field tokenizer: character codes, quote-mode type,
// tokenizer state and token structs. No dependencies.
`timescale 1ns / 1ps

package csvft_pkg;

    localparam int CODE_W = 16;

    localparam logic [CODE_W-1:0] CH_COMMA = 16'h002C;
    localparam logic [CODE_W-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CODE_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CODE_W-1:0] CH_CR    = 16'h000D;

    typedef enum logic [1:0] {
        QM_UNQUOTED   = 2'd0,
        QM_IN_QUOTES  = 2'd1,
        QM_QUOTE_SEEN = 2'd2
    } qmode_t;

    typedef struct packed {
        qmode_t qmode;
        logic   pending_cr;
        logic   field_nonempty;
        logic   row_nonempty;
    } tok_state_t;

    localparam tok_state_t TOK_STATE_RESET = '{
        qmode:          QM_UNQUOTED,
        pending_cr:     1'b0,
        field_nonempty: 1'b0,
        row_nonempty:   1'b0
    };

    typedef struct packed {
        logic [CODE_W-1:0] field_char;
        logic              has_char;
        logic              end_field;
        logic              end_row;
    } tok_result_t;

endpackage

[rtl/csvft_step.sv]
// One tokenizer step: next state, emit flag and token for one input item.
// Purely combinational; depends on csvft_pkg.
`timescale 1ns / 1ps

module csvft_step (
    input  csvft_pkg::tok_state_t          state_cur,
    input  logic [csvft_pkg::CODE_W-1:0]   code_unit,
    input  logic                           is_end,
    output csvft_pkg::tok_state_t          state_nxt,
    output logic                           emit,
    output csvft_pkg::tok_result_t         token
);
    import csvft_pkg::*;

    logic unquoted_path;

    always_comb begin
        state_nxt     = state_cur;
        emit          = 1'b0;
        token         = '0;
        unquoted_path = 1'b0;

        if (is_end) begin
            // Flush an open field or row, then return to the reset state.
            state_nxt       = TOK_STATE_RESET;
            emit            = state_cur.field_nonempty | state_cur.row_nonempty;
            token.end_field = 1'b1;
            token.end_row   = 1'b1;
        end else begin
            state_nxt.pending_cr = 1'b0;
            if (state_cur.pending_cr && code_unit == CH_LF) begin
                // LF of a CR LF pair: the row already ended on the CR.
                emit = 1'b0;
            end else begin
                unique case (state_cur.qmode)
                    QM_IN_QUOTES: begin
                        if (code_unit == CH_QUOTE) begin
                            state_nxt.qmode = QM_QUOTE_SEEN;
                        end else begin
                            state_nxt.field_nonempty = 1'b1;
                            emit                     = 1'b1;
                            token.field_char         = code_unit;
                            token.has_char           = 1'b1;
                        end
                    end
                    QM_QUOTE_SEEN: begin
                        if (code_unit == CH_QUOTE) begin
                            // Doubled quote stands for one literal quote.
                            state_nxt.qmode          = QM_IN_QUOTES;
                            state_nxt.field_nonempty = 1'b1;
                            emit                     = 1'b1;
                            token.field_char         = CH_QUOTE;
                            token.has_char           = 1'b1;
                        end else begin
                            // Quotes close; this unit is handled as unquoted.
                            unquoted_path = 1'b1;
                        end
                    end
                    default: begin
                        unquoted_path = 1'b1;
                    end
                endcase

                if (unquoted_path) begin
                    state_nxt.qmode = QM_UNQUOTED;
                    if (code_unit == CH_QUOTE) begin
                        state_nxt.qmode = QM_IN_QUOTES;
                    end else if (code_unit == CH_COMMA) begin
                        state_nxt.field_nonempty = 1'b0;
                        state_nxt.row_nonempty   = 1'b1;
                        emit                     = 1'b1;
                        token.end_field          = 1'b1;
                    end else if (code_unit == CH_LF || code_unit == CH_CR) begin
                        state_nxt.field_nonempty = 1'b0;
                        state_nxt.row_nonempty   = 1'b0;
                        state_nxt.pending_cr     = (code_unit == CH_CR);
                        emit                     = 1'b1;
                        token.end_field          = 1'b1;
                        token.end_row            = 1'b1;
                    end else begin
                        state_nxt.field_nonempty = 1'b1;
                        emit                     = 1'b1;
                        token.field_char         = code_unit;
                        token.has_char           = 1'b1;
                    end
                end
            end
        end
    end

endmodule

[rtl/csv_field_tokenizer_core.sv]
// Top level of the CSV field tokenizer: input register, tokenizer step and
// result register. Depends on csvft_pkg and csvft_step.
`timescale 1ns / 1ps
// Path: an accepted item waits in the input register, passes through csvft_step
// and its token is held in the result register until the master side takes it.
// Throughput: one item per cycle while the result register is free (not stalled
// by m_tready); items that yield no token simply leave no result behind.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the tokenizer state to unquoted with all flags clear.

module csv_field_tokenizer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [csvft_pkg::CODE_W-1:0] s_tdata,   // [15:0] code_unit
    input  logic [0:0]                   s_tuser,   // [0] is_end
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [csvft_pkg::CODE_W-1:0] m_tdata,   // [15:0] field_char
    output logic [1:0]                   m_tuser,   // [0] has_char, [1] end_field
    output logic                         m_tlast    // end_row
);
    import csvft_pkg::*;

    // Input register: holds one accepted item until the step logic takes it.
    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_end_reg;

    // Tokenizer state, updated when the held item is processed.
    tok_state_t state_reg;
    tok_state_t state_next;

    // Result register.
    logic        out_valid_reg;
    tok_result_t out_reg;

    logic        step_emit;
    tok_result_t step_token;
    logic        out_free;
    logic        advance;

    // The result register can take a new token when it is empty or being
    // drained this cycle. The held item advances under the same condition,
    // whether or not it produces a token.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    csvft_step u_step (
        .state_cur (state_reg),
        .code_unit (in_code_reg),
        .is_end    (in_end_reg),
        .state_nxt (state_next),
        .emit      (step_emit),
        .token     (step_token)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= TOK_STATE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                out_valid_reg <= advance && step_emit;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_code_reg <= s_tdata;
            in_end_reg  <= s_tuser[0];
        end
        if (advance && step_emit) begin
            out_reg <= step_token;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.field_char;
    assign m_tuser  = {out_reg.end_field, out_reg.has_char};
    assign m_tlast  = out_reg.end_row;

endmodule

[rtl/csvft_checker.sv]
// Port-level checker for the CSV field tokenizer, bound to the top level.
// Depends on csv_field_tokenizer_core.
`timescale 1ns / 1ps

module csvft_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A row end always comes with a field end.
    a_row_has_field: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("end_row without end_field");

    // A token is either a character or an end, never both nor neither.
    a_char_xor_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] != m_tuser[1]))
        else $error("token is not exactly one of character or field end");

    // End tokens carry a zero character.
    a_end_zero_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'h0000))
        else $error("end token with nonzero field_char");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    // No result in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind csv_field_tokenizer_core csvft_checker u_csvft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/sv/csv_field_tokenizer_core_tb.sv]
// Self-checking testbench for csv_field_tokenizer_core: predicts every token
// from the text stream and compares what the block emits. Depends on csvft_pkg.
`timescale 1ns / 1ps

module csv_field_tokenizer_core_tb;

    import csvft_pkg::*;

    // Tracks the tokenizer state on the side of the testbench and keeps the
    // tokens that the block still owes, oldest first.
    class csv_token_tracker;
        qmode_t      quote_state;
        bit          cr_ended_row;
        bit          field_open;
        bit          row_open;
        tok_result_t owed_tokens[$];
        int          mismatch_count;

        function new();
            quote_state    = QM_UNQUOTED;
            cr_ended_row   = 1'b0;
            field_open     = 1'b0;
            row_open       = 1'b0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] token check failed: %s", $realtime, msg);
            mismatch_count++;
        endtask

        function int owed_count();
            return owed_tokens.size();
        endfunction

        // Advances the predicted state by one accepted item and queues the
        // token that item produces, if any.
        function void predict_token(input bit [CODE_W-1:0] unit, input bit is_end);
            tok_result_t tok;
            bit          emits;
            bit          after_cr;
            tok   = '0;
            emits = 1'b0;
            if (is_end) begin
                // The end marker flushes whatever is open and clears all state.
                emits         = field_open || row_open;
                tok.end_field = 1'b1;
                tok.end_row   = 1'b1;
                quote_state   = QM_UNQUOTED;
                cr_ended_row  = 1'b0;
                field_open    = 1'b0;
                row_open      = 1'b0;
            end else begin
                after_cr     = cr_ended_row;
                cr_ended_row = 1'b0;
                // An LF right after a row-ending CR is swallowed.
                if (!(after_cr && unit == CH_LF)) begin
                    if (quote_state == QM_IN_QUOTES) begin
                        if (unit == CH_QUOTE) begin
                            quote_state = QM_QUOTE_SEEN;
                        end else begin
                            field_open     = 1'b1;
                            tok.field_char = unit;
                            tok.has_char   = 1'b1;
                            emits          = 1'b1;
                        end
                    end else if (quote_state == QM_QUOTE_SEEN && unit == CH_QUOTE) begin
                        // A doubled quote stands for one literal quote.
                        quote_state    = QM_IN_QUOTES;
                        field_open     = 1'b1;
                        tok.field_char = CH_QUOTE;
                        tok.has_char   = 1'b1;
                        emits          = 1'b1;
                    end else begin
                        // Unquoted text, or quotes that close here: the unit is taken as unquoted text.
                        quote_state = QM_UNQUOTED;
                        if (unit == CH_QUOTE) begin
                            quote_state = QM_IN_QUOTES;
                        end else if (unit == CH_COMMA) begin
                            field_open    = 1'b0;
                            row_open      = 1'b1;
                            tok.end_field = 1'b1;
                            emits         = 1'b1;
                        end else if (unit == CH_LF || unit == CH_CR) begin
                            field_open    = 1'b0;
                            row_open      = 1'b0;
                            cr_ended_row  = (unit == CH_CR);
                            tok.end_field = 1'b1;
                            tok.end_row   = 1'b1;
                            emits         = 1'b1;
                        end else begin
                            field_open     = 1'b1;
                            tok.field_char = unit;
                            tok.has_char   = 1'b1;
                            emits          = 1'b1;
                        end
                    end
                end
            end
            if (emits) begin
                owed_tokens.push_back(tok);
            end
        endfunction

        // Compares one emitted token with the oldest owed token, field by field.
        task check_token(input bit [CODE_W-1:0] fchar, input bit hchar, input bit efield,
                         input bit erow);
            tok_result_t want;
            if (owed_tokens.size() == 0) begin
                report_mismatch($sformatf("token char=%h has=%0b ef=%0b er=%0b not owed",
                                          fchar, hchar, efield, erow));
            end else begin
                want = owed_tokens.pop_front();
                if (fchar !== want.field_char)
                    report_mismatch($sformatf("field_char %h, want %h", fchar, want.field_char));
                if (hchar !== want.has_char)
                    report_mismatch($sformatf("has_char %0b, want %0b", hchar, want.has_char));
                if (efield !== want.end_field)
                    report_mismatch($sformatf("end_field %0b, want %0b", efield, want.end_field));
                if (erow !== want.end_row)
                    report_mismatch($sformatf("end_row %0b, want %0b", erow, want.end_row));
            end
        endtask
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CODE_W-1:0] s_tdata  = '0;
    logic [0:0]        s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CODE_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    csv_token_tracker tracker;
    int               burst_left = 0;
    int               items_sent = 0;

    csv_field_tokenizer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] code_unit
        .s_tuser  (s_tuser),    // [0] is_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] field_char
        .m_tuser  (m_tuser),    // [0] has_char, [1] end_field
        .m_tlast  (m_tlast)     // end_row
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, before any of this
    // step's nonblocking updates land. An item passes the input and result registers
    // before its token comes out, so predicting first and checking second is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.predict_token(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
                tracker.check_token(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
        end
    end

    // The receiver runs through stretches of its own: always ready, ready
    // at random, ready with a chance of one in four, and short full stalls.
    int ready_mode = 0;
    int ready_left = 0;
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = (ready_mode == 3) ? $urandom_range(1, 12) : $urandom_range(16, 200);
        end
        ready_left--;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    // Random text unit: mostly lower-case letters, sometimes any 16-bit value.
    function automatic bit [CODE_W-1:0] text_unit();
        if ($urandom_range(0, 3) == 0)
            return CODE_W'($urandom);
        return CODE_W'($urandom_range(16'h0061, 16'h007A));
    endfunction

    // Offers one item and returns at the edge where it is accepted. The sender
    // works in bursts; between bursts valid drops for a random gap. Valid gets
    // exactly one nonblocking update per time step.
    task automatic send_item(input bit [CODE_W-1:0] unit, input bit is_end);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tuser  <= is_end;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Holds the sender off until every owed token has come out. The first
    // edge lets the monitor record the item that was just accepted.
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.owed_count() != 0);
    endtask

    initial begin
        int nfields;
        int kind;
        int sel;
        int wait_cycles;
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. End marker on an empty state, with a unit that must
        // be ignored.
        send_item(16'hFFFF, 1'b1);
        // Extreme code units as plain text, then a comma.
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(CH_COMMA, 1'b0);
        // CR LF ends one row only; a second LF ends another row.
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_LF, 1'b0);
        // Quoted field holding a comma, a CR and a doubled quote.
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        // Closing quote followed by plain text in the same field.
        send_item(CH_QUOTE, 1'b0);
        send_item(16'h0062, 1'b0);
        // The row left open after a comma is flushed by the end marker.
        send_item(CH_COMMA, 1'b0);
        send_item(16'h0000, 1'b1);
        // An empty quoted field at the end of text flushes nothing.
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(16'h0000, 1'b1);
        // A pending field is flushed; the comma under the marker is ignored.
        send_item(16'h0078, 1'b0);
        send_item(CH_COMMA, 1'b1);
        // CR CR ends two rows; a quote after CR just opens a field.
        send_item(CH_CR, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(16'hFFFF, 1'b1);
        drain_tokens();

        // Random part: mostly well-formed rows with random content, plus
        // noise, end markers anywhere and an occasional full drain.
        while (items_sent < 1300) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                nfields = $urandom_range(1, 5);
                for (int f = 0; f < nfields; f++) begin
                    if (f != 0)
                        send_item(CH_COMMA, 1'b0);
                    kind = $urandom_range(0, 9);
                    if (kind >= 6) begin
                        send_item(CH_QUOTE, 1'b0);
                        repeat ($urandom_range(0, 6)) begin
                            case ($urandom_range(0, 7))
                                0: send_item(CH_COMMA, 1'b0);
                                1: send_item(CH_CR, 1'b0);
                                2: send_item(CH_LF, 1'b0);
                                3: begin
                                    send_item(CH_QUOTE, 1'b0);
                                    send_item(CH_QUOTE, 1'b0);
                                end
                                default: send_item(text_unit(), 1'b0);
                            endcase
                        end
                        send_item(CH_QUOTE, 1'b0);
                        // Now and then, text right after the closing quote.
                        if ($urandom_range(0, 7) == 0)
                            send_item(text_unit(), 1'b0);
                    end else if (kind >= 1) begin
                        repeat ($urandom_range(1, 6)) send_item(text_unit(), 1'b0);
                    end
                end
                case ($urandom_range(0, 3))
                    0: send_item(CH_LF, 1'b0);
                    1: send_item(CH_CR, 1'b0);
                    default: begin
                        send_item(CH_CR, 1'b0);
                        send_item(CH_LF, 1'b0);
                    end
                endcase
            end else if (sel < 80) begin
                send_item(CODE_W'($urandom), 1'b1);
            end else if (sel < 97) begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 9))
                        0: send_item(CH_COMMA, 1'b0);
                        1: send_item(CH_QUOTE, 1'b0);
                        2: send_item(CH_LF, 1'b0);
                        3: send_item(CH_CR, 1'b0);
                        4: send_item(CODE_W'($urandom), 1'b1);
                        default: send_item(CODE_W'($urandom), 1'b0);
                    endcase
                end
            end else begin
                drain_tokens();
            end
        end

        // Let the last tokens out, then allow for the input and result registers.
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge aclk);
            wait_cycles++;
        end while (tracker.owed_count() != 0 && wait_cycles < 20000);
        repeat (8) @(posedge aclk);
        if (tracker.owed_count() != 0)
            tracker.report_mismatch($sformatf("%0d tokens never came out",
                                              tracker.owed_count()));
        if (tracker.mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
